// File: hw/rtl/blws_pkg.sv
// ----------------------------------------------------------------------------
// Bounded list package
// Types, command and status codes, and sizes shared by the list cells and the
// top level.
// ----------------------------------------------------------------------------
package blws_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [2:0] CMD_ADD_HEAD  = 3'd0;
	localparam logic [2:0] CMD_ADD_TAIL  = 3'd1;
	localparam logic [2:0] CMD_DEL_HEAD  = 3'd2;
	localparam logic [2:0] CMD_DEL_VALUE = 3'd3;
	localparam logic [2:0] CMD_SEARCH    = 3'd4;
	localparam logic [2:0] CMD_READ      = 3'd5;
	localparam logic [2:0] CMD_CLEAR     = 3'd6;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
		logic [3:0]         index;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         position;
		logic signed [31:0] read_value;
		logic [4:0]         count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     capture;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

// File: hw/rtl/bounded_list_with_search.sv
// A command is registered on its transfer and the block moves to its execute state;
// the result is registered as that state ends, and no new command is taken before
// then. The cell compare is registered on the transfer and the chain shifts in the
// execute state. A stalled result holds the block in its execute state until taken.
// Reset clears the entry count and the handshake state; entry storage in
// the cells is not cleared.
// ----------------------------------------------------------------------------
// Bounded list with search
// Ordered list held in a chain of cells, head in cell zero, with add, delete,
// search, read and clear commands and one result per command.
// ----------------------------------------------------------------------------
module bounded_list_with_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  blws_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output blws_pkg::rsp_item_t rsp
);

	blws_pkg::state_t    state_q;
	blws_pkg::state_t    state_d;
	blws_pkg::cmd_item_t cmd_q;
	blws_pkg::rsp_item_t rsp_q;
	blws_pkg::rsp_item_t rsp_d;
	logic                rsp_valid_q;
	logic [blws_pkg::CNT_W-1:0] count_q;
	logic [blws_pkg::CNT_W-1:0] count_d;

	logic accept;
	logic fire;

	logic signed [31:0]  cell_data  [blws_pkg::CAPACITY];
	logic                cell_match [blws_pkg::CAPACITY];
	blws_pkg::cell_op_t  cell_op    [blws_pkg::CAPACITY];
	blws_pkg::cell_ctl_t cell_ctl   [blws_pkg::CAPACITY];

	logic                       first_found;
	logic [blws_pkg::IDX_W-1:0] first_pos;
	logic signed [31:0]         sel_data;
	logic                       is_full;
	logic                       is_empty;
	logic                       idx_ok;

	// Control FSM
	always_comb begin
		state_d = state_q;
		case (state_q)
			blws_pkg::S_IDLE: if (cmd_valid) state_d = blws_pkg::S_EXEC;
			blws_pkg::S_EXEC: if (!rsp_valid_q || rsp_ready) state_d = blws_pkg::S_IDLE;
			default:          state_d = blws_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == blws_pkg::S_IDLE);
		fire      = (state_q == blws_pkg::S_EXEC) && (!rsp_valid_q || rsp_ready);
	end

	assign accept = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= blws_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	// First matching cell below the count, and the cell picked by the read index.
	always_comb begin
		first_found = 1'b0;
		first_pos   = '0;
		sel_data    = '0;
		for (int i = blws_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (32'(i) < 32'(count_q))) begin
				first_found = 1'b1;
				first_pos   = blws_pkg::IDX_W'(i);
			end
			if (32'(cmd_q.index) == 32'(i)) begin
				sel_data = cell_data[i];
			end
		end
	end

	assign is_full  = (count_q == blws_pkg::CNT_W'(blws_pkg::CAPACITY));
	assign is_empty = (count_q == '0);
	assign idx_ok   = (32'(cmd_q.index) < 32'(count_q));

	always_comb begin
		rsp_d   = '0;
		count_d = count_q;
		for (int i = 0; i < blws_pkg::CAPACITY; i++) begin
			cell_op[i] = blws_pkg::CELL_HOLD;
		end
		case (cmd_q.command)
			blws_pkg::CMD_ADD_HEAD: begin
				if (is_full) begin
					rsp_d.status = blws_pkg::STAT_FULL;
				end else begin
					cell_op[0] = blws_pkg::CELL_LOAD;
					for (int i = 1; i < blws_pkg::CAPACITY; i++) begin
						cell_op[i] = blws_pkg::CELL_FROM_PREV;
					end
					count_d = count_q + 1'b1;
				end
			end
			blws_pkg::CMD_ADD_TAIL: begin
				if (is_full) begin
					rsp_d.status = blws_pkg::STAT_FULL;
				end else begin
					for (int i = 0; i < blws_pkg::CAPACITY; i++) begin
						if (32'(count_q) == 32'(i)) cell_op[i] = blws_pkg::CELL_LOAD;
					end
					count_d = count_q + 1'b1;
				end
			end
			blws_pkg::CMD_DEL_HEAD: begin
				if (is_empty) begin
					rsp_d.status = blws_pkg::STAT_EMPTY;
				end else begin
					for (int i = 0; i < blws_pkg::CAPACITY - 1; i++) begin
						cell_op[i] = blws_pkg::CELL_FROM_NEXT;
					end
					count_d = count_q - 1'b1;
				end
			end
			blws_pkg::CMD_DEL_VALUE: begin
				if (is_empty) begin
					rsp_d.status = blws_pkg::STAT_EMPTY;
				end else if (!first_found) begin
					rsp_d.status = blws_pkg::STAT_NOTFOUND;
				end else begin
					// Entries from the match onward move one place toward the head.
					for (int i = 0; i < blws_pkg::CAPACITY - 1; i++) begin
						if (32'(i) >= 32'(first_pos)) cell_op[i] = blws_pkg::CELL_FROM_NEXT;
					end
					count_d = count_q - 1'b1;
				end
			end
			blws_pkg::CMD_SEARCH: begin
				if (is_empty) begin
					rsp_d.status = blws_pkg::STAT_EMPTY;
				end else if (!first_found) begin
					rsp_d.status = blws_pkg::STAT_NOTFOUND;
				end else begin
					rsp_d.position = 4'(first_pos);
				end
			end
			blws_pkg::CMD_READ: begin
				if (is_empty) begin
					rsp_d.status = blws_pkg::STAT_EMPTY;
				end else if (!idx_ok) begin
					rsp_d.status = blws_pkg::STAT_NOTFOUND;
				end else begin
					rsp_d.read_value = sel_data;
				end
			end
			blws_pkg::CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		rsp_d.count = 5'(count_d);
	end

	for (genvar g = 0; g < blws_pkg::CAPACITY; g++) begin : g_cell
		logic signed [31:0] prev_d;
		logic signed [31:0] next_d;

		assign cell_ctl[g].op      = fire ? cell_op[g] : blws_pkg::CELL_HOLD;
		assign cell_ctl[g].capture = accept;

		if (g == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid
			assign prev_d = cell_data[g-1];
		end

		if (g == blws_pkg::CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_inner
			assign next_d = cell_data[g+1];
		end

		blws_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.cmp_value  (cmd.value),
			.load_value (cmd_q.value),
			.prev_data  (prev_d),
			.next_data  (next_d),
			.data       (cell_data[g]),
			.match      (cell_match[g])
		);
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(blws_pkg::CAPACITY))
		else $error("entry count exceeds capacity");

	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid)
		else $error("executed command produced no result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == blws_pkg::STAT_FULL) |->
		(rsp.count == 5'(blws_pkg::CAPACITY)))
		else $error("full status with a list that is not full");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd_q.command == blws_pkg::CMD_CLEAR) |=> (count_q == '0))
		else $error("clear left entries in the list");

endmodule

// File: hw/rtl/blws_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry, shifts toward either neighbor or loads a new value,
// and registers whether its entry equals the value of the incoming command.
// ----------------------------------------------------------------------------
module blws_cell (
	input  logic                clk,
	input  blws_pkg::cell_ctl_t ctl,
	input  logic signed [31:0]  cmp_value,
	input  logic signed [31:0]  load_value,
	input  logic signed [31:0]  prev_data,
	input  logic signed [31:0]  next_data,
	output logic signed [31:0]  data,
	output logic                match
);

	logic signed [31:0] data_q;
	logic               match_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			blws_pkg::CELL_LOAD:      data_q <= load_value;
			blws_pkg::CELL_FROM_PREV: data_q <= prev_data;
			blws_pkg::CELL_FROM_NEXT: data_q <= next_data;
			default:                  data_q <= data_q;
		endcase
	end

	// The compare is taken on the command transfer, while the entry is stable.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_q <= (data_q == cmp_value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list with search testbench
// Sends list commands through a bursty driver, predicts each response from a
// local copy of the list, and checks every response field against it while
// the response side stalls on a pattern that changes over the run.
// ----------------------------------------------------------------------------
module testbench;

	// Command code with no meaning; the block must answer it without change.
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int         NUM_RANDOM = 1200;
	localparam int         IDLE_LIMIT = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	blws_pkg::cmd_item_t cmd = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	blws_pkg::rsp_item_t rsp;

	blws_pkg::cmd_item_t pending_cmds[$];
	blws_pkg::rsp_item_t expected_rsps[$];
	int                  mismatches = 0;

	// Local copy of the list, head at index zero.
	logic signed [31:0] list_vals [blws_pkg::CAPACITY];
	int                 list_len = 0;

	bounded_list_with_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one command to the local list and returns the response it should give.
	function automatic blws_pkg::rsp_item_t apply_list_command(blws_pkg::cmd_item_t c);
		blws_pkg::rsp_item_t r;
		int                  hit;
		r = '0;
		hit = -1;
		if (c.command == blws_pkg::CMD_DEL_VALUE || c.command == blws_pkg::CMD_SEARCH) begin
			for (int i = 0; i < list_len; i++)
				if (hit < 0 && list_vals[i] == c.value)
					hit = i;
		end
		case (c.command)
			blws_pkg::CMD_ADD_HEAD: begin
				if (list_len >= blws_pkg::CAPACITY) begin
					r.status = blws_pkg::STAT_FULL;
				end else begin
					for (int i = list_len; i > 0; i--)
						list_vals[i] = list_vals[i - 1];
					list_vals[0] = c.value;
					list_len++;
				end
			end
			blws_pkg::CMD_ADD_TAIL: begin
				if (list_len >= blws_pkg::CAPACITY) begin
					r.status = blws_pkg::STAT_FULL;
				end else begin
					list_vals[list_len] = c.value;
					list_len++;
				end
			end
			blws_pkg::CMD_DEL_HEAD, blws_pkg::CMD_DEL_VALUE: begin
				if (c.command == blws_pkg::CMD_DEL_HEAD)
					hit = 0;
				if (list_len == 0) begin
					r.status = blws_pkg::STAT_EMPTY;
				end else if (hit < 0) begin
					r.status = blws_pkg::STAT_NOTFOUND;
				end else begin
					for (int i = hit; i < list_len - 1; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
				end
			end
			blws_pkg::CMD_SEARCH: begin
				if (list_len == 0)
					r.status = blws_pkg::STAT_EMPTY;
				else if (hit < 0)
					r.status = blws_pkg::STAT_NOTFOUND;
				else
					r.position = 4'(hit);
			end
			blws_pkg::CMD_READ: begin
				if (list_len == 0)
					r.status = blws_pkg::STAT_EMPTY;
				else if (int'(c.index) >= list_len)
					r.status = blws_pkg::STAT_NOTFOUND;
				else
					r.read_value = list_vals[c.index];
			end
			blws_pkg::CMD_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.count = 5'(list_len);
		return r;
	endfunction

	task automatic send_command(input logic [2:0] op, input logic signed [31:0] v,
			input logic [3:0] idx);
		blws_pkg::cmd_item_t item;
		item.command = op;
		item.value = v;
		item.index = idx;
		pending_cmds.push_back(item);
	endtask

	// Driver: bursts of transfers separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			burst_left = 0;
			gap_left = 0;
		end else if (!cmd_valid || cmd_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				cmd_valid <= 1'b1;
				cmd <= pending_cmds.pop_front();
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Response side stalls in one of several modes, changed each time the six-bit stall phase wraps.
	logic [5:0] stall_phase = '0;
	int         stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_phase = '0;
		end else begin
			stall_phase++;
			if (stall_phase == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom_range(0, 1));
				2: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= (stall_phase[2:0] < 3'd5);
			endcase
		end
	end

	// Monitor: predicts on each command transfer, then checks each response transfer.
	blws_pkg::rsp_item_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_rsps.delete();
			list_len = 0;
		end else begin
			if (cmd_valid && cmd_ready)
				expected_rsps.push_back(apply_list_command(cmd));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no command waiting: status %0d count %0d",
						rsp.status, rsp.count);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position,
							rsp.position);
						mismatches++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value,
							rsp.read_value);
						mismatches++;
					end
					if (rsp.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, rsp.count);
						mismatches++;
					end
				end
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic signed [31:0] tail_val;
		logic signed [31:0] value_pool [6];
		logic signed [31:0] v;
		logic [2:0]         op;
		int                 add_weight;
		int                 roll;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Operations on an empty list.
		send_command(blws_pkg::CMD_SEARCH, 32'sd5, 4'd0);
		send_command(blws_pkg::CMD_DEL_HEAD, 32'sd0, 4'd0);
		send_command(blws_pkg::CMD_READ, 32'sd0, 4'd0);

		// Fill to capacity from both ends, with the extreme values in the mix.
		tail_val = '0;
		for (int i = 0; i < blws_pkg::CAPACITY; i++) begin
			v = (i == 0) ? -32'sd1 : (i == 1) ? 32'sh80000000 : (i == 2) ? 32'sh7fffffff
				: $urandom;
			if (i % 2 == 1) begin
				send_command(blws_pkg::CMD_ADD_HEAD, v, 4'd0);
			end else begin
				send_command(blws_pkg::CMD_ADD_TAIL, v, 4'd0);
				tail_val = v;
			end
		end

		// Full list: both pushes refused, then lookups at the far end.
		send_command(blws_pkg::CMD_ADD_HEAD, 32'sd1, 4'd0);
		send_command(blws_pkg::CMD_ADD_TAIL, 32'sd2, 4'd0);
		send_command(blws_pkg::CMD_SEARCH, tail_val, 4'd0);
		send_command(blws_pkg::CMD_SEARCH, 32'sd12345, 4'd0);
		send_command(blws_pkg::CMD_READ, 32'sd0, 4'd15);
		send_command(blws_pkg::CMD_DEL_VALUE, 32'sh7fffffff, 4'd0);
		send_command(blws_pkg::CMD_DEL_HEAD, 32'sd0, 4'd0);
		send_command(blws_pkg::CMD_READ, 32'sd0, 4'd14);
		send_command(CMD_UNUSED, 32'sd0, 4'd0);
		send_command(blws_pkg::CMD_CLEAR, 32'sd0, 4'd0);
		send_command(blws_pkg::CMD_DEL_VALUE, 32'sd3, 4'd0);

		// Hold the sender until everything sent so far has come back.
		// The checks sit on the falling edge, where the driver's updates have settled.
		while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
			@(negedge clk);

		add_weight = 40;
		for (int n = 0; n < NUM_RANDOM; n++) begin
			// Values mostly come from a small pool so searches and deletes find hits.
			if (n % 100 == 0) begin
				foreach (value_pool[k])
					value_pool[k] = $urandom;
				if ($urandom_range(0, 1) == 1)
					value_pool[0] = 32'sh80000000;
				if ($urandom_range(0, 1) == 1)
					value_pool[1] = 32'sh7fffffff;
			end
			// Phases that favor growth, shrinkage or neither.
			if (n % 60 == 0)
				add_weight = ($urandom_range(0, 2) == 0) ? 60
					: ($urandom_range(0, 1) == 0) ? 20 : 40;
			if (n == NUM_RANDOM / 2) begin
				while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
					@(negedge clk);
			end

			if ($urandom_range(0, 99) < add_weight) begin
				op = ($urandom_range(0, 1) == 0) ? blws_pkg::CMD_ADD_HEAD
					: blws_pkg::CMD_ADD_TAIL;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 15)
					op = blws_pkg::CMD_DEL_HEAD;
				else if (roll < 41)
					op = blws_pkg::CMD_DEL_VALUE;
				else if (roll < 67)
					op = blws_pkg::CMD_SEARCH;
				else if (roll < 93)
					op = blws_pkg::CMD_READ;
				else if (roll < 94)
					op = blws_pkg::CMD_CLEAR;
				else
					op = CMD_UNUSED;
			end
			v = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 5)] : $urandom;
			send_command(op, v, 4'($urandom_range(0, 15)));

			// Keep the pending queue short so pauses line up with the stimulus.
			while (pending_cmds.size() > 8)
				@(posedge clk);
		end

		while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/blws_pkg.sv
hw/rtl/blws_cell.sv
hw/rtl/bounded_list_with_search.sv
tb/testbench.sv
